FILE: design/mdpt_pkg.sv
// Shared types and constants for the multichannel delayed pulse timer.
// Used by mdpt_mem, mdpt_seq and multichannel_delayed_pulse_timer.
package mdpt_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_W    = 16;

    localparam logic [CH_AW-1:0] LAST_CH = CH_AW'(CHANNELS - 1);

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_TRIGGER  = 3'd1;
    localparam logic [2:0] KIND_SET_PRE  = 3'd2;
    localparam logic [2:0] KIND_SET_HOLD = 3'd3;
    localparam logic [2:0] KIND_ALL_OFF  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_ONE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] pre;
        logic [7:0] hold;
        logic [7:0] cd;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [CH_AW-1:0] waddr;
        t_entry           wdata;
    } t_mem_wr;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] bits;
    } t_res;

endpackage

FILE: design/mdpt_mem.sv
// Per-channel state memory: pre-delay, hold time and countdown per entry.
// One write port and one read port with registered read data; uses mdpt_pkg.
module mdpt_mem (
    input  logic                        i_clk,
    input  mdpt_pkg::t_mem_wr           i_wr,
    input  logic [mdpt_pkg::CH_AW-1:0]  i_raddr,
    output mdpt_pkg::t_entry            o_rdata
);
    import mdpt_pkg::*;

    t_entry r_mem [CHANNELS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.waddr] <= i_wr.wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mdpt_seq.sv
// Sequencer for the pulse timer: read-modify-write of channel entries in mdpt_mem,
// entry valid bits, and the output bit register. Uses mdpt_pkg.
module mdpt_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_kind,
    input  logic [5:0]                  i_channel,
    input  logic [7:0]                  i_time_value,
    input  logic                        i_slot_free,
    output mdpt_pkg::t_res              o_res,
    output mdpt_pkg::t_mem_wr           o_wr,
    output logic [mdpt_pkg::CH_AW-1:0]  o_raddr,
    input  mdpt_pkg::t_entry            i_rdata
);
    import mdpt_pkg::*;

    t_state              r_state,    n_state;
    logic [CH_AW-1:0]    r_idx,      n_idx;
    logic [2:0]          r_kind,     n_kind;
    logic                r_ch_ok,    n_ch_ok;
    logic [7:0]          r_tv,       n_tv;
    logic [CHANNELS-1:0] r_tab_vld,  n_tab_vld;
    logic [CHANNELS-1:0] r_cd_vld,   n_cd_vld;
    logic [CHANNELS-1:0] r_out_bits, n_out_bits;

    logic             acc;
    logic             ch_ok_in;
    logic [CH_AW-1:0] ch_idx_in;
    t_entry           ent;
    t_entry           mod;
    logic [7:0]       cd_dec;
    logic             done;

    assign acc       = i_in_valid && (r_state == S_IDLE);
    assign ch_ok_in  = {1'b0, i_channel} < 7'(CHANNELS);
    assign ch_idx_in = i_channel[CH_AW-1:0];

    always_comb begin
        ent.pre  = r_tab_vld[r_idx] ? i_rdata.pre  : 8'd0;
        ent.hold = r_tab_vld[r_idx] ? i_rdata.hold : 8'd0;
        ent.cd   = r_cd_vld[r_idx]  ? i_rdata.cd   : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tab_vld  <= '0;
            r_cd_vld   <= '0;
            r_out_bits <= '0;
        end else begin
            r_state    <= n_state;
            r_tab_vld  <= n_tab_vld;
            r_cd_vld   <= n_cd_vld;
            r_out_bits <= n_out_bits;
        end
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_ch_ok <= n_ch_ok;
        r_tv    <= n_tv;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_kind     = r_kind;
        n_ch_ok    = r_ch_ok;
        n_tv       = r_tv;
        n_tab_vld  = r_tab_vld;
        n_cd_vld   = r_cd_vld;
        n_out_bits = r_out_bits;
        mod        = ent;
        cd_dec     = ent.cd - 8'd1;
        o_wr       = '0;
        o_raddr    = r_idx + CH_AW'(1);
        done       = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_raddr = (i_kind == KIND_TICK) ? '0 : ch_idx_in;
                if (acc) begin
                    n_kind  = i_kind;
                    n_ch_ok = ch_ok_in;
                    n_tv    = i_time_value;
                    n_idx   = (i_kind == KIND_TICK) ? '0 : ch_idx_in;
                    case (i_kind)
                        KIND_TICK: begin
                            n_state = S_TICK;
                        end
                        KIND_TRIGGER, KIND_SET_PRE, KIND_SET_HOLD: begin
                            n_state = S_ONE;
                        end
                        KIND_ALL_OFF: begin
                            n_cd_vld   = '0;
                            n_out_bits = '0;
                            n_state    = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (ent.cd != 8'd0) begin
                    mod.cd = cd_dec;
                    if (cd_dec == 8'd0) begin
                        if (!r_out_bits[r_idx]) begin
                            mod.cd = ent.hold;
                        end
                        n_out_bits[r_idx] = !r_out_bits[r_idx];
                    end
                end
                o_wr.we           = 1'b1;
                o_wr.waddr        = r_idx;
                o_wr.wdata        = mod;
                n_tab_vld[r_idx]  = 1'b1;
                n_cd_vld[r_idx]   = 1'b1;
                if (r_idx == LAST_CH) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + CH_AW'(1);
                end
            end
            S_ONE: begin
                case (r_kind)
                    KIND_TRIGGER: begin
                        if (ent.cd == 8'd0) begin
                            mod.cd = ent.pre;
                        end
                    end
                    KIND_SET_PRE: begin
                        mod.pre = r_tv;
                    end
                    KIND_SET_HOLD: begin
                        mod.hold = r_tv;
                    end
                    default: begin
                    end
                endcase
                o_wr.we    = r_ch_ok;
                o_wr.waddr = r_idx;
                o_wr.wdata = mod;
                if (r_ch_ok) begin
                    n_tab_vld[r_idx] = 1'b1;
                    n_cd_vld[r_idx]  = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_res.done = done;
    assign o_res.bits = OUT_W'(r_out_bits);

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !o_wr.we)
        else $error("memory written outside a modify state");

    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == KIND_TICK) |=> (r_state == S_TICK && r_idx == '0))
        else $error("tick did not start its channel walk at entry zero");

    a_all_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == KIND_ALL_OFF) |=> (r_cd_vld == '0 && r_out_bits == '0))
        else $error("all-off left a countdown or an output bit set");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_idx != LAST_CH) |=>
        (r_state == S_TICK && r_idx == $past(r_idx) + CH_AW'(1)))
        else $error("tick walk skipped or repeated a channel");

endmodule

FILE: design/multichannel_delayed_pulse_timer.sv
// Multichannel delayed pulse timer top level: mdpt_seq, mdpt_mem and the result register.
// A tick walks every channel in S_TICK, one read-modify-write of the state memory per
// channel per cycle; a trigger or table write does one read-modify-write in S_ONE; all-off
// and unused kinds go straight to S_DONE. S_DONE waits until the result register is free. A
// new beat is taken only in S_IDLE, while a result may still wait in the result register.
// Synchronous active-low reset clears all tables, countdowns and output bits to zero.
module multichannel_delayed_pulse_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [5:0]  i_channel,
    input  logic [7:0]  i_time_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_channel_outputs
);
    import mdpt_pkg::*;

    t_res             res;
    t_mem_wr          wr;
    logic [CH_AW-1:0] raddr;
    t_entry           rdata;
    logic             slot_free;
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;

    assign slot_free = !r_out_vld || !i_out_stall;

    mdpt_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_channel    (i_channel),
        .i_time_value (i_time_value),
        .i_slot_free  (slot_free),
        .o_res        (res),
        .o_wr         (wr),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    mdpt_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (res.done) begin
            r_out_data <= res.bits;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_channel_outputs = r_out_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> !(r_out_vld && i_out_stall))
        else $error("result beat overwritten while stalled");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |=> (r_out_vld && r_out_data == $past(res.bits)))
        else $error("finished item did not reach the result register");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> o_in_stall)
        else $error("result produced while no item was in progress");

endmodule
